>>> hdl/assert_macros.svh
// assertion macros shared by the rtl of the point-in-polygon block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> hdl/pip_eo_pkg.sv
// types and constants of the even-odd point-in-polygon block
`timescale 1ns / 1ps

package pip_eo_pkg;

    // coordinate width of the query point and the vertices
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;

    // vertex count, saturating at three
    typedef logic [1:0] t_vcount;
    localparam t_vcount VC_NONE = 2'd0;
    localparam t_vcount VC_ONE  = 2'd1;
    localparam t_vcount VC_FULL = 2'd3;

    // edge slots: the incoming edge and the closing edge
    localparam int EDGE_IN    = 0;
    localparam int EDGE_CLOSE = 1;
    localparam int NUM_EDGES  = 2;

    // one edge from a to b
    typedef struct packed {
        logic   en;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_edge;

    // per-edge terms after the multiply stage
    typedef struct packed {
        logic  en;
        logic  in_box;
        logic  in_span;
        t_prod touch_p;
        t_prod touch_q;
        t_prod cross_p;
        t_prod cross_q;
    } t_edge_term;

endpackage

>>> hdl/point_in_polygon_even_odd.sv
// even-odd point-in-polygon test with boundary detection, one vertex per beat
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Input channel (i_in_valid / o_in_stall): one vertex per beat. i_first_vertex
//   opens a polygon and samples the query point; i_last_vertex closes it. A
//   vertex that arrives with no polygon open opens one and keeps the held point.
//   Output channel (o_out_valid / i_out_stall): one beat per closed polygon,
//   o_inside_res (on an edge or odd crossings, if not too few) and o_too_few_vertices.
// Throughput: one vertex beat per cycle unless stalled, closing one included.
// Path: input capture, one multiply stage (eight 17x17 products, four each
//   for the incoming and closing edges), then compare and accumulate into
//   the result register.
// Stall: while a result waits in the output register and i_out_stall is high,
//   the whole pipeline holds and o_in_stall is high; otherwise a vertex is
//   taken every cycle, also while the result register holds a finished beat
//   that is being taken.
// Reset: synchronous, active low; clears the pipeline, the open polygon and
//   the held query point (to the origin).
module point_in_polygon_even_odd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_first_vertex,
    input  logic                i_last_vertex,
    input  pip_eo_pkg::t_coord  i_point_x,
    input  pip_eo_pkg::t_coord  i_point_y,
    input  pip_eo_pkg::t_coord  i_vertex_x,
    input  pip_eo_pkg::t_coord  i_vertex_y,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_inside_res,
    output logic                o_too_few_vertices
);
    import pip_eo_pkg::*;

    // front-end polygon state
    t_coord  r_query_x, r_query_y;
    t_coord  r_start_x, r_start_y;
    t_coord  r_prev_x, r_prev_y;
    t_vcount r_count;

    // stage 1: edges of the item
    logic    r_s1_valid, r_s1_open, r_s1_last, r_s1_few;
    t_coord  r_s1_px, r_s1_py;
    t_edge   r_s1_edge [NUM_EDGES];

    // stage 2: products and range flags
    logic       r_s2_valid, r_s2_open, r_s2_last, r_s2_few;
    t_edge_term r_s2_term [NUM_EDGES];

    // accumulated flags of the open polygon
    logic r_touch, r_parity;

    // result register
    logic r_out_valid, r_out_inside, r_out_few;

    logic    adv, accept;
    logic    n_open;
    t_vcount n_count;
    t_coord  n_query_x, n_query_y, n_start_x, n_start_y;
    t_edge   n_edge [NUM_EDGES];
    t_edge_term n_term [NUM_EDGES];
    logic    n_touch, n_parity, n_base_touch, n_base_parity;

    // pipeline moves when the result register is free or being taken
    assign adv        = !(r_out_valid && i_out_stall);
    assign accept     = i_in_valid && adv;
    assign o_in_stall = !adv;

    // open, count, query point and the incoming and closing edges of the vertex
    always_comb begin
        n_open    = i_first_vertex || (r_count == VC_NONE);
        n_query_x = i_first_vertex ? i_point_x : r_query_x;
        n_query_y = i_first_vertex ? i_point_y : r_query_y;
        n_start_x = n_open ? i_vertex_x : r_start_x;
        n_start_y = n_open ? i_vertex_y : r_start_y;
        if (n_open) begin
            n_count = VC_ONE;
        end else if (r_count == VC_FULL) begin
            n_count = VC_FULL;
        end else begin
            n_count = r_count + VC_ONE;
        end
        n_edge[EDGE_IN]    = '{en: !n_open, ax: r_prev_x, ay: r_prev_y,
                               bx: i_vertex_x, by: i_vertex_y};
        n_edge[EDGE_CLOSE] = '{en: i_last_vertex, ax: i_vertex_x, ay: i_vertex_y,
                               bx: n_start_x, by: n_start_y};
    end

    // front-end state update on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= VC_NONE;
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (accept) begin
            r_query_x <= n_query_x;
            r_query_y <= n_query_y;
            r_count   <= i_last_vertex ? VC_NONE : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start_x <= n_start_x;
            r_start_y <= n_start_y;
            r_prev_x  <= i_vertex_x;
            r_prev_y  <= i_vertex_y;
        end
    end

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_open <= n_open;
            r_s1_last <= i_last_vertex;
            r_s1_few  <= (n_count != VC_FULL);
            r_s1_px   <= n_query_x;
            r_s1_py   <= n_query_y;
            for (int e = 0; e < NUM_EDGES; e++) begin
                r_s1_edge[e] <= n_edge[e];
            end
        end
    end

    // per-edge differences, products and range tests
    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            t_coord minx, maxx, miny, maxy, lx, ux;
            t_diff  dax, day, dbx, dby, dux, dpy, dpx, duy;
            minx = (r_s1_edge[e].ax < r_s1_edge[e].bx) ? r_s1_edge[e].ax : r_s1_edge[e].bx;
            maxx = (r_s1_edge[e].ax < r_s1_edge[e].bx) ? r_s1_edge[e].bx : r_s1_edge[e].ax;
            miny = (r_s1_edge[e].ay < r_s1_edge[e].by) ? r_s1_edge[e].ay : r_s1_edge[e].by;
            maxy = (r_s1_edge[e].ay < r_s1_edge[e].by) ? r_s1_edge[e].by : r_s1_edge[e].ay;
            lx   = (r_s1_edge[e].ay < r_s1_edge[e].by) ? r_s1_edge[e].ax : r_s1_edge[e].bx;
            ux   = (r_s1_edge[e].ay < r_s1_edge[e].by) ? r_s1_edge[e].bx : r_s1_edge[e].ax;
            // collinearity terms relative to the point
            dax  = t_diff'(r_s1_edge[e].ax) - t_diff'(r_s1_px);
            day  = t_diff'(r_s1_edge[e].ay) - t_diff'(r_s1_py);
            dbx  = t_diff'(r_s1_edge[e].bx) - t_diff'(r_s1_px);
            dby  = t_diff'(r_s1_edge[e].by) - t_diff'(r_s1_py);
            // crossing terms relative to the lower endpoint
            dux  = t_diff'(ux) - t_diff'(lx);
            dpy  = t_diff'(r_s1_py) - t_diff'(miny);
            dpx  = t_diff'(r_s1_px) - t_diff'(lx);
            duy  = t_diff'(maxy) - t_diff'(miny);
            n_term[e].en      = r_s1_edge[e].en;
            n_term[e].in_box  = (r_s1_px >= minx) && (r_s1_px <= maxx) &&
                                (r_s1_py >= miny) && (r_s1_py <= maxy);
            n_term[e].in_span = (r_s1_edge[e].ay != r_s1_edge[e].by) &&
                                (r_s1_py > miny) && (r_s1_py <= maxy);
            n_term[e].touch_p = t_prod'(dax) * t_prod'(dby);
            n_term[e].touch_q = t_prod'(day) * t_prod'(dbx);
            n_term[e].cross_p = t_prod'(dux) * t_prod'(dpy);
            n_term[e].cross_q = t_prod'(dpx) * t_prod'(duy);
        end
    end

    // stage 2 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_open <= r_s1_open;
            r_s2_last <= r_s1_last;
            r_s2_few  <= r_s1_few;
            for (int e = 0; e < NUM_EDGES; e++) begin
                r_s2_term[e] <= n_term[e];
            end
        end
    end

    // touch and crossing decisions folded into the polygon flags
    always_comb begin
        n_base_touch  = r_s2_open ? 1'b0 : r_touch;
        n_base_parity = r_s2_open ? 1'b0 : r_parity;
        n_touch       = n_base_touch;
        n_parity      = n_base_parity;
        for (int e = 0; e < NUM_EDGES; e++) begin
            n_touch  = n_touch | (r_s2_term[e].en && r_s2_term[e].in_box &&
                                  (r_s2_term[e].touch_p == r_s2_term[e].touch_q));
            n_parity = n_parity ^ (r_s2_term[e].en && r_s2_term[e].in_span &&
                                   (r_s2_term[e].cross_p >= r_s2_term[e].cross_q));
        end
    end

    // polygon flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch     <= 1'b0;
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_touch  <= r_s2_last ? 1'b0 : n_touch;
                r_parity <= r_s2_last ? 1'b0 : n_parity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && r_s2_last) begin
            r_out_inside <= !r_s2_few && (n_touch || n_parity);
            r_out_few    <= r_s2_few;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_inside_res       = r_out_inside;
    assign o_too_few_vertices = r_out_few;

    // checks
    `ASSERT_SAME(a_res_exclusive, i_clk, i_rst_n, o_out_valid,
        !(o_inside_res && o_too_few_vertices), "inside and too-few set together")
    `ASSERT_SAME(a_stall_only_full, i_clk, i_rst_n, o_in_stall,
        r_out_valid && i_out_stall, "input stalled without a held result")
    `ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, accept && i_last_vertex,
        r_count == VC_NONE, "polygon still open after its last vertex")
    `ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, adv && r_s2_valid && r_s2_last,
        r_out_valid, "closing beat did not reach the result register")

endmodule
